[sv/lr_pkg.sv]
// ----------------------------------------------------------------------------
// lr_pkg - shared types and constants for the line rasterizer
// Holds the request codes, register indexes and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // register indexes on the csr port
   localparam int   CSR_INDEX_BITS    = 1;
   localparam logic CSR_WINDOW_LEFT   = 1'b0;
   localparam logic CSR_WINDOW_BOTTOM = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch ordered endpoints
      logic setup;     // compute extents and error term
      logic step;      // emit current pixel, advance
   } lr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;      // current pixel is the final one
   } lr_sts_type;

endpackage

`default_nettype wire

[sv/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// line_rasterizer - Bresenham line rasterizer, top level
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_x/y_first/second
//   rsp      out        rsp_valid/rsp_stall  rsp_column, rsp_row,
//                                            rsp_last_pixel, rsp_outside
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A step transaction emits the current pixel; pixels stream at one per clock while
// the response side does not stall. A load transaction orders the endpoints
// on acceptance and then sets up extents and the error term in a setup state,
// during which req_stall is high. Pixel results sit in an output register; a new
// request is taken while the held pixel is being accepted. Reset clears the
// window registers and ends any active line. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic                               req_type,
   input  wire logic signed [COORD_BITS-1:0]       req_x_first,
   input  wire logic signed [COORD_BITS-1:0]       req_y_first,
   input  wire logic signed [COORD_BITS-1:0]       req_x_second,
   input  wire logic signed [COORD_BITS-1:0]       req_y_second,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [COORD_BITS-1:0]              rsp_column,
   output      logic [COORD_BITS-1:0]              rsp_row,
   output      logic                               rsp_last_pixel,
   output      logic                               rsp_outside,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [lr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]              csr_data
);

   lr_pkg::lr_cmd_type cmd;
   lr_pkg::lr_sts_type sts;

   assign csr_ready = 1'b1;

   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   lr_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .x_first    (req_x_first),
      .y_first    (req_y_first),
      .x_second   (req_x_second),
      .y_second   (req_y_second),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .column     (rsp_column),
      .row        (rsp_row),
      .last_pixel (rsp_last_pixel),
      .outside    (rsp_outside)
   );

endmodule

`default_nettype wire

[sv/lr_dp.sv]
// ----------------------------------------------------------------------------
// lr_dp - line rasterizer datapath
// Endpoint ordering, Bresenham setup, per-pixel stepping, window offset and
// the registered pixel output. Also holds the window registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_dp #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lr_pkg::lr_cmd_type                 cmd,
   output      lr_pkg::lr_sts_type                 sts,
   input  wire logic signed [COORD_BITS-1:0]       x_first,
   input  wire logic signed [COORD_BITS-1:0]       y_first,
   input  wire logic signed [COORD_BITS-1:0]       x_second,
   input  wire logic signed [COORD_BITS-1:0]       y_second,
   input  wire logic                               csr_write,
   input  wire logic [lr_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]              csr_data,
   output      logic [COORD_BITS-1:0]              column,
   output      logic [COORD_BITS-1:0]              row,
   output      logic                               last_pixel,
   output      logic                               outside
);

   localparam int N  = COORD_BITS;
   localparam int DW = COORD_BITS + 1;   // extent width
   localparam int EW = COORD_BITS + 3;   // error term width

   // window registers
   logic signed [N-1:0] win_left_ff, win_bottom_ff;

   // ordered endpoints
   logic signed [N-1:0] xa_ff, ya_ff, xb_ff, yb_ff;

   // line state
   logic signed [N-1:0]  cur_x_ff, cur_y_ff, major_end_ff;
   logic        [DW-1:0] dmaj_ff, dmin_ff;
   logic signed [EW-1:0] err_ff;
   logic                 y_major_ff, y_down_ff;

   // output registers
   logic [N-1:0] column_ff, row_ff;
   logic         last_ff, outside_ff;

   // ordering
   logic swap;

   // setup
   logic [DW-1:0]        dx, dy, dy_up, dy_down;
   logic                 y_down, y_major;
   logic [DW-1:0]        dmaj_in, dmin_in;
   logic signed [EW-1:0] err_setup;

   // step
   logic                 last, step_minor;
   logic signed [N-1:0]  y_next, x_inc;
   logic signed [EW-1:0] err_step;

   always_comb begin
      if (x_first != x_second) begin
         swap = x_first > x_second;
      end else begin
         swap = y_first > y_second;
      end
   end

   always_comb begin
      dx      = {xb_ff[N-1], xb_ff} - {xa_ff[N-1], xa_ff};
      dy_up   = {yb_ff[N-1], yb_ff} - {ya_ff[N-1], ya_ff};
      dy_down = {ya_ff[N-1], ya_ff} - {yb_ff[N-1], yb_ff};
      y_down  = yb_ff < ya_ff;
      dy      = y_down ? dy_down : dy_up;
      y_major = dy > dx;
      dmaj_in = y_major ? dy : dx;
      dmin_in = y_major ? dx : dy;
      err_setup = $signed({1'b0, dmin_in, 1'b0}) - $signed({2'b00, dmaj_in});
   end

   always_comb begin
      last       = (y_major_ff ? cur_y_ff : cur_x_ff) == major_end_ff;
      step_minor = !err_ff[EW-1] && (err_ff != '0);
      y_next     = y_down_ff ? cur_y_ff - N'(1) : cur_y_ff + N'(1);
      x_inc      = cur_x_ff + N'(1);
      err_step   = err_ff + $signed({1'b0, dmin_ff, 1'b0})
                 - (step_minor ? $signed({1'b0, dmaj_ff, 1'b0}) : $signed(EW'(0)));
   end

   assign sts.last = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= '0;
         win_bottom_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            lr_pkg::CSR_WINDOW_LEFT:   win_left_ff   <= csr_data;
            lr_pkg::CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         xa_ff <= swap ? x_second : x_first;
         ya_ff <= swap ? y_second : y_first;
         xb_ff <= swap ? x_first  : x_second;
         yb_ff <= swap ? y_first  : y_second;
      end

      if (cmd.setup) begin
         cur_x_ff     <= xa_ff;
         cur_y_ff     <= ya_ff;
         major_end_ff <= y_major ? yb_ff : xb_ff;
         dmaj_ff      <= dmaj_in;
         dmin_ff      <= dmin_in;
         err_ff       <= err_setup;
         y_major_ff   <= y_major;
         y_down_ff    <= y_down;
      end else if (cmd.step && !last) begin
         if (y_major_ff) begin
            cur_y_ff <= y_next;
            if (step_minor) cur_x_ff <= x_inc;
         end else begin
            cur_x_ff <= x_inc;
            if (step_minor) cur_y_ff <= y_next;
         end
         err_ff <= err_step;
      end

      if (cmd.step) begin
         column_ff  <= cur_x_ff - win_left_ff;
         row_ff     <= cur_y_ff - win_bottom_ff;
         last_ff    <= last;
         outside_ff <= (cur_x_ff < win_left_ff) || (cur_y_ff < win_bottom_ff);
      end
   end

   assign column     = column_ff;
   assign row        = row_ff;
   assign last_pixel = last_ff;
   assign outside    = outside_ff;

endmodule

`default_nettype wire

[sv/lr_ctrl.sv]
// ----------------------------------------------------------------------------
// lr_ctrl - line rasterizer controller
// Handshakes the request and response channels, tracks the active line and
// issues capture, setup and step commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_type,
   output      logic               req_stall,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      lr_pkg::lr_cmd_type cmd,
   input  wire lr_pkg::lr_sts_type sts
);

   typedef enum logic {
      ST_IDLE,
      ST_SETUP
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      req_accept;
   logic      rsp_accept;

   // hold requests during setup and while a pixel waits downstream
   assign req_stall  = (state_ff == ST_SETUP) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;

   always_comb begin
      cmd.capture = req_accept && (req_type == lr_pkg::REQ_LOAD);
      cmd.setup   = (state_ff == ST_SETUP);
      cmd.step    = req_accept && (req_type == lr_pkg::REQ_STEP) && busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_SETUP;
                  busy_ff  <= 1'b0;   // drop any active line
               end else if (cmd.step && sts.last) begin
                  busy_ff <= 1'b0;
               end
            end
            ST_SETUP: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (cmd.step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_step_needs_line : assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> busy_ff)
      else $error("step issued with no active line");

   a_setup_follows_capture : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.setup)
      else $error("setup did not follow capture");

   a_setup_one_cycle : assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> (!cmd.setup && busy_ff))
      else $error("setup not single cycle or line not active");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.step)
      else $error("pixel overwritten while stalled");

endmodule

`default_nettype wire

[verif/tb_line_rasterizer.sv]
// ----------------------------------------------------------------------------
// tb_line_rasterizer - self-checking bench for the Bresenham line rasterizer
// Drives load and step transactions, predicts every pixel with an in-bench
// model of the line walk and window offset, and checks each accepted pixel
// against the oldest expectation. A short table of directed transactions is
// followed by random lines under several sender/receiver idling mixes and
// window settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_line_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS      = lr_pkg::COORD_BITS_DEFAULT;
   localparam int DELTA_BITS      = COORD_BITS + 1;
   localparam int ERR_BITS        = COORD_BITS + 3;
   localparam int NUM_PHASES      = 4;
   localparam int ITEMS_PER_PHASE = 500;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 500000;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type column;
      coord_type row;
      logic      last_pixel;
      logic      outside;
   } pixel_type;

   typedef struct packed {
      logic      rtype;
      coord_type xf;
      coord_type yf;
      coord_type xs;
      coord_type ys;
      logic      known;
      pixel_type px;
   } stim_row_type;

   localparam pixel_type NO_PIXEL = '0;
   localparam int NUM_DIRECTED = 25;

   // window is at reset (0, 0) throughout this table
   localparam stim_row_type DIRECTED[NUM_DIRECTED] = '{
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_LOAD, 12'h800, 12'h800, 12'h800, 12'h800, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 1'b1,
        '{12'h800, 12'h800, 1'b1, 1'b1}},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_LOAD, 12'h7ff, 12'h7ff, 12'h7ff, 12'h7ff, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b1,
        '{12'h7ff, 12'h7ff, 1'b1, 1'b0}},
      // horizontal, given right to left
      '{lr_pkg::REQ_LOAD, 12'h003, 12'h000, 12'hfff, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h555, 12'haaa, 12'h555, 12'haaa, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      // vertical, given top to bottom
      '{lr_pkg::REQ_LOAD, 12'h000, 12'h002, 12'h000, 12'hfff, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      // steep, y decreasing
      '{lr_pkg::REQ_LOAD, 12'h000, 12'h000, 12'h003, 12'hffa, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      // full-range diagonal loaded over the active line, then dropped
      '{lr_pkg::REQ_LOAD, 12'h800, 12'h7ff, 12'h7ff, 12'h800, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_LOAD, 12'h005, 12'h001, 12'h001, 12'h003, 1'b0, NO_PIXEL},
      '{lr_pkg::REQ_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 1'b0, NO_PIXEL}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_type = lr_pkg::REQ_LOAD;
   logic signed [COORD_BITS-1:0] req_x_first = '0;
   logic signed [COORD_BITS-1:0] req_y_first = '0;
   logic signed [COORD_BITS-1:0] req_x_second = '0;
   logic signed [COORD_BITS-1:0] req_y_second = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_column;
   coord_type rsp_row;
   logic      rsp_last_pixel;
   logic      rsp_outside;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   logic [lr_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   coord_type csr_data = '0;

   // typed-in expectation travelling with the request payload
   logic      req_known = 1'b0;
   pixel_type req_known_px = '0;

   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        error_count = 0;
   int        cycle_count;
   pixel_type expected_pixels[$];

   // bench copy of the rasterizer state
   logic signed [COORD_BITS-1:0] win_left = '0;
   logic signed [COORD_BITS-1:0] win_bottom = '0;
   logic signed [COORD_BITS-1:0] line_x = '0;
   logic signed [COORD_BITS-1:0] line_y = '0;
   logic signed [COORD_BITS-1:0] line_major_end = '0;
   logic signed [COORD_BITS:0]   line_d_major = '0;
   logic signed [COORD_BITS:0]   line_d_minor = '0;
   logic signed [COORD_BITS+2:0] line_err = '0;
   logic      line_y_major = 1'b0;
   logic      line_y_down = 1'b0;
   logic      line_active = 1'b0;

   line_rasterizer #(
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_x_first   (req_x_first),
      .req_y_first   (req_y_first),
      .req_x_second  (req_x_second),
      .req_y_second  (req_y_second),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_last_pixel(rsp_last_pixel),
      .rsp_outside   (rsp_outside),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Load sets up a new line; step emits the current pixel and advances.
   // Returns 1 when the transaction produces a pixel.
   function automatic bit rasterize_request(input logic rtype,
                                            input logic signed [COORD_BITS-1:0] xa_in,
                                            input logic signed [COORD_BITS-1:0] ya_in,
                                            input logic signed [COORD_BITS-1:0] xb_in,
                                            input logic signed [COORD_BITS-1:0] yb_in,
                                            output pixel_type px);
      logic signed [COORD_BITS-1:0] xa, ya, xb, yb, t;
      logic signed [COORD_BITS:0]   dx, dy;
      bit swap, step_minor;
      px = '0;
      if (rtype == lr_pkg::REQ_LOAD) begin
         xa = xa_in;
         ya = ya_in;
         xb = xb_in;
         yb = yb_in;
         swap = (xa != xb) ? (xa > xb) : (ya > yb);
         if (swap) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
         end
         dx = DELTA_BITS'(xb) - DELTA_BITS'(xa);
         line_y_down = yb < ya;
         dy = line_y_down ? (DELTA_BITS'(ya) - DELTA_BITS'(yb))
                          : (DELTA_BITS'(yb) - DELTA_BITS'(ya));
         line_y_major = dy > dx;
         line_x = xa;
         line_y = ya;
         if (line_y_major) begin
            line_d_major = dy;
            line_d_minor = dx;
            line_major_end = yb;
         end else begin
            line_d_major = dx;
            line_d_minor = dy;
            line_major_end = xb;
         end
         line_err = ERR_BITS'(2 * line_d_minor - line_d_major);
         line_active = 1'b1;
         return 1'b0;
      end
      if (!line_active)
         return 1'b0;
      px.column = line_x - win_left;
      px.row = line_y - win_bottom;
      px.last_pixel = ((line_y_major ? line_y : line_x) == line_major_end);
      px.outside = (line_x < win_left) || (line_y < win_bottom);
      if (px.last_pixel) begin
         line_active = 1'b0;
      end else begin
         // minor axis moves only on a strictly positive error term
         step_minor = line_err > 0;
         if (line_y_major || step_minor) begin
            if (line_y_down)
               line_y = line_y - 1'b1;
            else
               line_y = line_y + 1'b1;
         end
         if (!line_y_major || step_minor)
            line_x = line_x + 1'b1;
         if (step_minor)
            line_err = line_err - ERR_BITS'(2 * line_d_major);
         line_err = line_err + ERR_BITS'(2 * line_d_minor);
      end
      return 1'b1;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom_range((1 << COORD_BITS) - 1));
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check accepted pixels, track register writes, predict accepted requests.
   always @(posedge clock) begin : monitor
      pixel_type got_px, want_px, pred_px;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_px = '{rsp_column, rsp_row, rsp_last_pixel, rsp_outside};
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel: column %0h row %0h last %0b outside %0b",
                      got_px.column, got_px.row, got_px.last_pixel, got_px.outside);
               error_count++;
            end else begin
               want_px = expected_pixels.pop_front();
               if (got_px.column !== want_px.column) begin
                  $error("column: expected %0h, got %0h", want_px.column, got_px.column);
                  error_count++;
               end
               if (got_px.row !== want_px.row) begin
                  $error("row: expected %0h, got %0h", want_px.row, got_px.row);
                  error_count++;
               end
               if (got_px.last_pixel !== want_px.last_pixel) begin
                  $error("last_pixel: expected %0b, got %0b",
                         want_px.last_pixel, got_px.last_pixel);
                  error_count++;
               end
               if (got_px.outside !== want_px.outside) begin
                  $error("outside: expected %0b, got %0b", want_px.outside, got_px.outside);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == lr_pkg::CSR_WINDOW_LEFT)
               win_left = csr_data;
            else if (csr_index == lr_pkg::CSR_WINDOW_BOTTOM)
               win_bottom = csr_data;
         end
         if (req_valid && !req_stall) begin
            if (rasterize_request(req_type, req_x_first, req_y_first,
                                  req_x_second, req_y_second, pred_px))
               expected_pixels = {expected_pixels, (req_known ? req_known_px : pred_px)};
         end
      end
   end

   // Present one transaction after random idle cycles; hold until accepted.
   task automatic send_item(input logic rtype, input coord_type xf, input coord_type yf,
                            input coord_type xs, input coord_type ys,
                            input logic known, input pixel_type known_px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rtype;
      req_x_first <= xf;
      req_y_first <= yf;
      req_x_second <= xs;
      req_y_second <= ys;
      req_known <= known;
      req_known_px <= known_px;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the monitor record the last accepted request first
      @(posedge clock);
      while (expected_pixels.size() != 0 || rsp_valid)
         @(posedge clock);
      // a load may still be in setup with nothing expected
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [lr_pkg::CSR_INDEX_BITS-1:0] index,
                                 input coord_type data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_rasterizer test failed");
      $finish;
   end

   initial begin : stimulus
      int        phase_items, pick, steps, pixels, dxa, dya;
      coord_type xf, yf, xs, ys;
      int        idle_send[NUM_PHASES];
      int        idle_recv[NUM_PHASES];
      idle_send = '{0, 78, 0, 11};
      idle_recv = '{0, 0, 78, 11};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(DIRECTED[i].rtype, DIRECTED[i].xf, DIRECTED[i].yf, DIRECTED[i].xs,
                   DIRECTED[i].ys, DIRECTED[i].known, DIRECTED[i].px);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         send_idle_pct = 0;
         recv_stall_pct = 0;
         case (phase)
            0: begin
               write_register(lr_pkg::CSR_WINDOW_LEFT, 12'h800);
               write_register(lr_pkg::CSR_WINDOW_BOTTOM, 12'h7ff);
            end
            1: begin
               write_register(lr_pkg::CSR_WINDOW_LEFT, 12'h7ff);
               write_register(lr_pkg::CSR_WINDOW_BOTTOM, 12'h800);
            end
            default: begin
               write_register(lr_pkg::CSR_WINDOW_LEFT, rand_coord());
               write_register(lr_pkg::CSR_WINDOW_BOTTOM, rand_coord());
            end
         endcase
         send_idle_pct = idle_send[phase];
         recv_stall_pct = idle_recv[phase];

         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            pick = int'($urandom_range(99));
            if (pick < 5) begin
               // stray step: idle or continuing whatever line is active
               send_item(lr_pkg::REQ_STEP, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), 1'b0, NO_PIXEL);
            end else begin
               xf = rand_coord();
               yf = rand_coord();
               if (pick < 80) begin
                  xs = coord_type'(xf + ($urandom_range(32) - 16));
                  ys = coord_type'(yf + ($urandom_range(32) - 16));
               end else begin
                  xs = rand_coord();
                  ys = rand_coord();
               end
               dxa = int'($signed(xs)) - int'($signed(xf));
               dya = int'($signed(ys)) - int'($signed(yf));
               if (dxa < 0) dxa = -dxa;
               if (dya < 0) dya = -dya;
               pixels = ((dxa > dya) ? dxa : dya) + 1;
               if (pick < 65)
                  steps = pixels
                        + (($urandom_range(3) == 0) ? int'($urandom_range(2, 1)) : 0);
               else if (pick < 80)
                  steps = int'($urandom_range(pixels - 1));
               else
                  steps = int'($urandom_range(40));
               // lines wrapped across the coordinate range are cut short
               if (steps > 64)
                  steps = 64;
               send_item(lr_pkg::REQ_LOAD, xf, yf, xs, ys, 1'b0, NO_PIXEL);
               for (int s = 0; s < steps; s++)
                  send_item(lr_pkg::REQ_STEP, rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), 1'b0, NO_PIXEL);
               phase_items += 1 + steps;
               if ($urandom_range(99) == 0)
                  wait_drained();
            end
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("line_rasterizer test passed");
      else
         $display("line_rasterizer test failed");
      $finish;
   end

endmodule

`default_nettype wire
